### src/ckre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckre_pkg
// Shared types and constants for the color key run extractor.
// ----------------------------------------------------------------------------
package ckre_pkg;

    localparam int COORD_W   = 13;
    localparam int KEY_W     = 24;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd3;

    localparam logic KIND_RUN = 1'b0;
    localparam logic KIND_BOX = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x_begin;
        logic [COORD_W-1:0] y_begin;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               empty_region;
        logic               last;
    } t_result;

endpackage

### src/ckre_key_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckre_key_match
// Per-channel window compare of a pixel against the key and tolerance bytes.
// ----------------------------------------------------------------------------
module ckre_key_match (
    input  logic [ckre_pkg::CHAN_W-1:0] i_chan_low,
    input  logic [ckre_pkg::CHAN_W-1:0] i_chan_mid,
    input  logic [ckre_pkg::CHAN_W-1:0] i_chan_high,
    input  logic [ckre_pkg::KEY_W-1:0]  i_key_color,
    input  logic [ckre_pkg::KEY_W-1:0]  i_key_tolerance,
    output logic                        o_transparent
);
    import ckre_pkg::*;

    logic [3*CHAN_W-1:0] pix;
    logic [2:0]          hit;

    assign pix = {i_chan_high, i_chan_mid, i_chan_low};

    // The upper bound keeps its carry bit, so a sum past 255 acts as a saturated bound.
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [CHAN_W:0] upper;
        assign upper  = {1'b0, i_key_color[c*CHAN_W +: CHAN_W]}
                      + {1'b0, i_key_tolerance[c*CHAN_W +: CHAN_W]};
        assign hit[c] = (pix[c*CHAN_W +: CHAN_W] >= i_key_color[c*CHAN_W +: CHAN_W])
                     && ({1'b0, pix[c*CHAN_W +: CHAN_W]} <= upper);
    end

    assign o_transparent = &hit;

endmodule

### src/ckre_run_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckre_run_track
// Scan position, open run and bounding box state; builds up to two results.
// ----------------------------------------------------------------------------
module ckre_run_track #(
    parameter int CW = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_transparent,
    input  logic [CW-1:0]     i_width,
    input  logic [CW-1:0]     i_height,
    output ckre_pkg::t_result o_res0,
    output ckre_pkg::t_result o_res1,
    output logic [1:0]        o_res_count
);
    import ckre_pkg::*;

    logic [CW-1:0] r_column, r_row, r_run_start;
    logic [CW-1:0] r_box_left, r_box_top, r_box_right, r_box_bottom;
    logic          r_run_open, r_any_run;

    logic [CW-1:0] col_inc, row_inc, run_x0, run_x1;
    logic [CW-1:0] box_l, box_t, box_r, box_b;
    logic          row_end, frame_end, close_now, close_end, emit, any_run;
    t_result       run_res, box_res;

    assign col_inc   = r_column + 1'b1;
    assign row_inc   = r_row + 1'b1;
    assign row_end   = col_inc >= i_width;
    assign frame_end = row_end && (row_inc >= i_height);

    // A transparent pixel closes an open run; an opaque pixel at the row end
    // closes the run it is part of, whether just opened or not.
    assign close_now = i_transparent && r_run_open;
    assign close_end = row_end && !i_transparent;
    assign emit      = close_now || close_end;
    assign run_x0    = r_run_open ? r_run_start : r_column;
    assign run_x1    = close_now ? r_column : col_inc;

    assign box_l   = (emit && run_x0 < r_box_left)   ? run_x0  : r_box_left;
    assign box_t   = (emit && r_row < r_box_top)     ? r_row   : r_box_top;
    assign box_r   = (emit && run_x1 > r_box_right)  ? run_x1  : r_box_right;
    assign box_b   = (emit && row_inc > r_box_bottom) ? row_inc : r_box_bottom;
    assign any_run = r_any_run || emit;

    always_comb begin
        run_res.kind         = KIND_RUN;
        run_res.x_begin      = COORD_W'(run_x0);
        run_res.y_begin      = COORD_W'(r_row);
        run_res.x_end        = COORD_W'(run_x1);
        run_res.y_end        = COORD_W'(row_inc);
        run_res.empty_region = 1'b0;
        run_res.last         = !frame_end;

        box_res.kind         = KIND_BOX;
        box_res.x_begin      = any_run ? COORD_W'(box_l) : '0;
        box_res.y_begin      = any_run ? COORD_W'(box_t) : '0;
        box_res.x_end        = any_run ? COORD_W'(box_r) : '0;
        box_res.y_end        = any_run ? COORD_W'(box_b) : '0;
        box_res.empty_region = !any_run;
        box_res.last         = 1'b1;
    end

    assign o_res0      = emit ? run_res : box_res;
    assign o_res1      = box_res;
    assign o_res_count = {1'b0, emit} + {1'b0, frame_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_row        <= '0;
            r_run_open   <= 1'b0;
            r_run_start  <= '0;
            r_box_left   <= '1;
            r_box_top    <= '1;
            r_box_right  <= '0;
            r_box_bottom <= '0;
            r_any_run    <= 1'b0;
        end else if (i_step) begin
            if (frame_end) begin
                r_column     <= '0;
                r_row        <= '0;
                r_run_open   <= 1'b0;
                r_run_start  <= '0;
                r_box_left   <= '1;
                r_box_top    <= '1;
                r_box_right  <= '0;
                r_box_bottom <= '0;
                r_any_run    <= 1'b0;
            end else begin
                r_column     <= row_end ? '0 : col_inc;
                r_row        <= row_end ? row_inc : r_row;
                r_run_open   <= !i_transparent && !row_end;
                r_run_start  <= run_x0;
                r_box_left   <= box_l;
                r_box_top    <= box_t;
                r_box_right  <= box_r;
                r_box_bottom <= box_b;
                r_any_run    <= any_run;
            end
        end
    end

endmodule

### src/ckre_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckre_out_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module ckre_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_count,
    input  ckre_pkg::t_result i_res0,
    input  ckre_pkg::t_result i_res1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ckre_pkg::t_result o_res
);
    import ckre_pkg::*;

    t_result                 r_entry [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_PTR_W:0]     r_count;
    logic                    pop;

    assign o_valid = r_count != '0;
    assign o_res   = r_entry[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // Room for the worst case of two results from one pixel.
    assign o_room  = r_count <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_entry[r_wr_ptr + 1'b1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push_count);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_count  <= r_count + (FIFO_PTR_W+1)'(i_push_count)
                      - (FIFO_PTR_W+1)'(pop);
        end
    end

endmodule

### src/color_key_run_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_key_run_extractor_top
// Color key run extractor: opaque runs per row and the frame bounding box.
// ----------------------------------------------------------------------------
// Pixels enter in scan order, one word per clock. Each pixel sits in an input
// register while the key compare and run/box update run, and its
// results (none, one or two) go into a four-entry result queue. A new pixel is
// taken every cycle as long as the queue has room for two words; the queue
// drains one word per clock while the receiver is ready; a pixel that ends a run
// at the last column of the frame adds two words. Frame size writes are clamped to
// the range 1..MAX_DIM when taken. Configuration writes are accepted at once.
module color_key_run_extractor_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ckre_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ckre_pkg::KEY_W-1:0]       i_cfg_data,

    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [ckre_pkg::CHAN_W-1:0]      i_chan_low,
    input  logic [ckre_pkg::CHAN_W-1:0]      i_chan_mid,
    input  logic [ckre_pkg::CHAN_W-1:0]      i_chan_high,

    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_kind,
    output logic [ckre_pkg::COORD_W-1:0]     o_x_begin,
    output logic [ckre_pkg::COORD_W-1:0]     o_y_begin,
    output logic [ckre_pkg::COORD_W-1:0]     o_x_end,
    output logic [ckre_pkg::COORD_W-1:0]     o_y_end,
    output logic                             o_empty_region,
    output logic                             o_last
);
    import ckre_pkg::*;

    localparam int CW = $clog2(MAX_DIM + 1);

    logic [KEY_W-1:0]  r_key_color, r_key_tolerance;
    logic [CW-1:0]     r_frame_w, r_frame_h;
    logic              r_pix_valid;
    logic [CHAN_W-1:0] r_chan_low, r_chan_mid, r_chan_high;

    logic              transparent, room, advance;
    logic [1:0]        res_count;
    t_result           res0, res1, out_res;
    logic [CW-1:0]     size_clamped;
    logic [COORD_W-1:0] size_raw;

    // A size of 0 acts as 1, anything past MAX_DIM as MAX_DIM.
    assign size_raw = i_cfg_data[COORD_W-1:0];
    always_comb begin
        if (size_raw == '0) begin
            size_clamped = CW'(1);
        end else if (size_raw > MAX_DIM) begin
            size_clamped = CW'(MAX_DIM);
        end else begin
            size_clamped = CW'(size_raw);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color     <= '0;
            r_key_tolerance <= '0;
            r_frame_w       <= CW'(1);
            r_frame_h       <= CW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_COLOR:     r_key_color     <= i_cfg_data;
                CFG_KEY_TOLERANCE: r_key_tolerance <= i_cfg_data;
                CFG_FRAME_WIDTH:   r_frame_w       <= size_clamped;
                CFG_FRAME_HEIGHT:  r_frame_h       <= size_clamped;
                default: ;
            endcase
        end
    end

    assign advance = r_pix_valid && room;
    assign o_ready = !r_pix_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (o_ready) begin
            r_pix_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_chan_low  <= i_chan_low;
            r_chan_mid  <= i_chan_mid;
            r_chan_high <= i_chan_high;
        end
    end

    ckre_key_match u_key_match (
        .i_chan_low      (r_chan_low),
        .i_chan_mid      (r_chan_mid),
        .i_chan_high     (r_chan_high),
        .i_key_color     (r_key_color),
        .i_key_tolerance (r_key_tolerance),
        .o_transparent   (transparent)
    );

    ckre_run_track #(
        .CW (CW)
    ) u_run_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_transparent (transparent),
        .i_width       (r_frame_w),
        .i_height      (r_frame_h),
        .o_res0        (res0),
        .o_res1        (res1),
        .o_res_count   (res_count)
    );

    ckre_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (advance ? res_count : 2'd0),
        .i_res0       (res0),
        .i_res1       (res1),
        .o_room       (room),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_res        (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_x_begin      = out_res.x_begin;
    assign o_y_begin      = out_res.y_begin;
    assign o_x_end        = out_res.x_end;
    assign o_y_end        = out_res.y_end;
    assign o_empty_region = out_res.empty_region;
    assign o_last         = out_res.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the color key run extractor.
// ----------------------------------------------------------------------------
// A short directed table hits the reset defaults, the key bounds, tolerance
// saturation, the size clamps and a size change in the middle of a frame.
// Random phases follow: each one may pick a new key, tolerance and frame size and
// streams pixels made of opaque and transparent runs. Two long frames follow,
// one with the width and one with the height clamped to the maximum, and each
// is cut short by a size change. An in-bench raster model predicts every run
// and box word, and the output monitor compares each accepted word with the
// oldest prediction. The input side pauses between bursts of random length,
// and the output side stalls on patterns of its own, with two long hold-offs
// that back the block up into its input.
module testbench;
    import ckre_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int RANDOM_ITEMS = 1000;
    localparam int WIDE_PIXELS  = 200;
    localparam int TALL_PIXELS  = 150;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic {ROW_PIX, ROW_CFG} t_row_op;

    // One step of the directed table: a register write or one pixel word.
    // A pixel row with typed results pushes those instead of the prediction.
    typedef struct {
        t_row_op                op;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [KEY_W-1:0]       value;
        int                     n_typed;
        t_result                want0;
        t_result                want1;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [KEY_W-1:0]       i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [CHAN_W-1:0]      i_chan_low = '0;
    logic [CHAN_W-1:0]      i_chan_mid = '0;
    logic [CHAN_W-1:0]      i_chan_high = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_kind;
    logic [COORD_W-1:0]     o_x_begin;
    logic [COORD_W-1:0]     o_y_begin;
    logic [COORD_W-1:0]     o_x_end;
    logic [COORD_W-1:0]     o_y_end;
    logic                   o_empty_region;
    logic                   o_last;

    color_key_run_extractor_top #(
        .MAX_DIM(MAX_DIM)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_chan_low     (i_chan_low),
        .i_chan_mid     (i_chan_mid),
        .i_chan_high    (i_chan_high),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_x_begin      (o_x_begin),
        .o_y_begin      (o_y_begin),
        .o_x_end        (o_x_end),
        .o_y_end        (o_y_end),
        .o_empty_region (o_empty_region),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Raster model state and its copy of the registers.
    logic [KEY_W-1:0]   key_q = '0;
    logic [KEY_W-1:0]   tol_q = '0;
    logic [COORD_W-1:0] width_q = 13'd1;
    logic [COORD_W-1:0] height_q = 13'd1;
    int unsigned        col_pos, row_pos, run_from;
    int unsigned        box_l, box_t, box_r, box_b;
    bit                 run_live, saw_run;
    t_result            step_res [2];
    int                 step_cnt;

    t_result            expected_rects [$];
    t_dir_row           dir_rows [$];

    int                 errors = 0;
    int                 pixels_in = 0;
    int                 frames_seen = 0;
    int                 reg_writes = 0;
    int                 words_checked = 0;
    int                 burst_left = 0;
    int                 cycle_count = 0;
    bit                 clear_run = 1'b0;

    function automatic t_result rect(input logic kind, input int unsigned xb, yb, xe, ye,
                                     input logic empty, input logic fin);
        t_result r;
        r.kind         = kind;
        r.x_begin      = xb[COORD_W-1:0];
        r.y_begin      = yb[COORD_W-1:0];
        r.x_end        = xe[COORD_W-1:0];
        r.y_end        = ye[COORD_W-1:0];
        r.empty_region = empty;
        r.last         = fin;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [KEY_W-1:0] data);
        t_dir_row r;
        r.op      = ROW_CFG;
        r.reg_idx = idx;
        r.value   = data;
        r.n_typed = 0;
        r.want0   = '0;
        r.want1   = '0;
        return r;
    endfunction

    function automatic t_dir_row pix_row(input logic [KEY_W-1:0] px, input int n = 0,
                                         input t_result a = '0, input t_result b = '0);
        t_dir_row r;
        r.op      = ROW_PIX;
        r.reg_idx = CFG_KEY_COLOR;
        r.value   = px;
        r.n_typed = n;
        r.want0   = a;
        r.want1   = b;
        return r;
    endfunction

    function automatic int unsigned dim(input logic [COORD_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Upper bound of the transparent range of one channel, saturated at 255.
    function automatic int clear_top(input int k);
        int hi;
        hi = int'(key_q[8*k +: 8]) + int'(tol_q[8*k +: 8]);
        return (hi > 255) ? 255 : hi;
    endfunction

    function automatic bit byte_keyed(input logic [7:0] b, input int k);
        return int'(b) >= int'(key_q[8*k +: 8]) && int'(b) <= clear_top(k);
    endfunction

    task automatic restart_frame();
        col_pos  = 0;
        row_pos  = 0;
        run_live = 1'b0;
        run_from = 0;
        box_l    = 13'h1fff;
        box_t    = 13'h1fff;
        box_r    = 0;
        box_b    = 0;
        saw_run  = 1'b0;
    endtask

    task automatic close_run(input int unsigned x0, input int unsigned x1);
        step_res[step_cnt] = rect(KIND_RUN, x0, row_pos, x1, row_pos + 1, 1'b0, 1'b0);
        step_cnt++;
        if (x0 < box_l) box_l = x0;
        if (row_pos < box_t) box_t = row_pos;
        if (x1 > box_r) box_r = x1;
        if (row_pos + 1 > box_b) box_b = row_pos + 1;
        saw_run = 1'b1;
    endtask

    // Works out the run and box words that one pixel produces.
    task automatic advance_raster(input logic [KEY_W-1:0] px);
        int unsigned w, h;
        bit          clear, row_end, frame_end;
        w = dim(width_q);
        h = dim(height_q);
        clear = byte_keyed(px[7:0], 0) && byte_keyed(px[15:8], 1) &&
                byte_keyed(px[23:16], 2);
        row_end   = col_pos + 1 >= w;
        frame_end = row_end && row_pos + 1 >= h;
        step_cnt  = 0;
        if (clear) begin
            if (run_live) begin
                close_run(run_from, col_pos);
                run_live = 1'b0;
            end
        end else if (!run_live) begin
            run_live = 1'b1;
            run_from = col_pos;
        end
        // A run still open at the last column closes ahead of any box word.
        if (row_end && run_live) begin
            close_run(run_from, col_pos + 1);
            run_live = 1'b0;
        end
        if (frame_end) begin
            if (saw_run)
                step_res[step_cnt] = rect(KIND_BOX, box_l, box_t, box_r, box_b, 1'b0, 1'b0);
            else
                step_res[step_cnt] = rect(KIND_BOX, 0, 0, 0, 0, 1'b1, 1'b0);
            step_cnt++;
            frames_seen++;
            restart_frame();
        end else if (row_end) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
    endtask

    // Draws a pixel inside the key range, or one that misses it on one channel,
    // usually right next to a bound.
    function automatic logic [KEY_W-1:0] pick_pixel(input bit want_clear);
        logic [KEY_W-1:0] px;
        int               lo, hi, k;
        for (k = 0; k < 3; k++) begin
            lo = int'(key_q[8*k +: 8]);
            hi = clear_top(k);
            case ($urandom_range(0, 3))
                0: begin
                    px[8*k +: 8] = 8'(lo);
                end
                1: begin
                    px[8*k +: 8] = 8'(hi);
                end
                default: begin
                    px[8*k +: 8] = 8'($urandom_range(hi, lo));
                end
            endcase
        end
        if (!want_clear) begin
            k  = $urandom_range(0, 2);
            lo = int'(key_q[8*k +: 8]);
            hi = clear_top(k);
            if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 1))
                px[8*k +: 8] = 8'(lo - 1);
            else if (hi < 255)
                px[8*k +: 8] = 8'(hi + 1);
            else
                px = KEY_W'($urandom());
        end
        return px;
    endfunction

    function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_pixel(input logic [KEY_W-1:0] px, input int n_typed = 0,
                              input t_result a = '0, input t_result b = '0);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_chan_low  = px[7:0];
        i_chan_mid  = px[15:8];
        i_chan_high = px[23:16];
        do @(posedge i_clk); while (!o_ready);
        pixels_in++;
        advance_raster(px);
        if (n_typed == 0) begin
            for (int k = 0; k < step_cnt; k++) expected_rects.push_back(step_res[k]);
        end else begin
            expected_rects.push_back(a);
            if (n_typed > 1) expected_rects.push_back(b);
        end
    endtask

    task automatic stream_pixels(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0) clear_run = ~clear_run;
            if ($urandom_range(0, 9) == 0)
                send_pixel(KEY_W'($urandom()));
            else
                send_pixel(pick_pixel(clear_run));
        end
    endtask

    // Registers change only once the block has drained and gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (expected_rects.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            CFG_KEY_COLOR: begin
                key_q = data;
            end
            CFG_KEY_TOLERANCE: begin
                tol_q = data;
            end
            CFG_FRAME_WIDTH: begin
                width_q = data[COORD_W-1:0];
            end
            CFG_FRAME_HEIGHT: begin
                height_q = data[COORD_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Output side: changing stall patterns, plus long hold-offs at two points.
    initial begin : drain_side
        int mode, mode_left, tick, hold_idx;
        int hold_marks [2];
        hold_marks = '{300, 900};
        mode_left  = 0;
        tick       = 0;
        hold_idx   = 0;
        wait (i_rst_n);
        forever begin
            if (hold_idx < 2 && pixels_in >= hold_marks[hold_idx]) begin
                hold_idx++;
                @(negedge i_clk);
                i_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            tick++;
            @(negedge i_clk);
            case (mode)
                0: i_ready = 1'b1;
                1: i_ready = $urandom_range(0, 1) == 1;
                2: i_ready = $urandom_range(0, 3) == 0;
                default: i_ready = (tick % 3) != 0;
            endcase
        end
    end

    always @(posedge i_clk) begin : compare_output
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rects.size() == 0) begin
                $error("result word with no expected result pending");
                errors++;
            end else begin
                want = expected_rects.pop_front();
                check_field("kind", COORD_W'(want.kind), COORD_W'(o_kind));
                check_field("x_begin", want.x_begin, o_x_begin);
                check_field("y_begin", want.y_begin, o_y_begin);
                check_field("x_end", want.x_end, o_x_end);
                check_field("y_end", want.y_end, o_y_end);
                check_field("empty_region", COORD_W'(want.empty_region),
                            COORD_W'(o_empty_region));
                check_field("last", COORD_W'(want.last), COORD_W'(o_last));
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        int                 stop_at, n, fr, drain;
        logic [KEY_W-1:0]   wdata;
        int unsigned        wv;
        restart_frame();

        // Defaults after reset: key 0, no tolerance, one-pixel frames.
        dir_rows.push_back(pix_row(24'h000000, 1, rect(KIND_BOX, 0, 0, 0, 0, 1'b1, 1'b1)));
        dir_rows.push_back(pix_row(24'hFFFFFF, 2, rect(KIND_RUN, 0, 0, 1, 1, 1'b0, 1'b0),
                                   rect(KIND_BOX, 0, 0, 1, 1, 1'b0, 1'b1)));
        dir_rows.push_back(pix_row(24'h000001, 2, rect(KIND_RUN, 0, 0, 1, 1, 1'b0, 1'b0),
                                   rect(KIND_BOX, 0, 0, 1, 1, 1'b0, 1'b1)));
        dir_rows.push_back(pix_row(24'h010000, 2, rect(KIND_RUN, 0, 0, 1, 1, 1'b0, 1'b0),
                                   rect(KIND_BOX, 0, 0, 1, 1, 1'b0, 1'b1)));
        // Bounds on each channel, the middle one saturating; width with junk
        // above bit 12 and a zero height.
        dir_rows.push_back(cfg_row(CFG_KEY_COLOR, 24'h804020));
        dir_rows.push_back(cfg_row(CFG_KEY_TOLERANCE, 24'h10FF00));
        dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 24'hFFE004));
        dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 24'h000000));
        dir_rows.push_back(pix_row(24'h804020));
        dir_rows.push_back(pix_row(24'h80401F));
        dir_rows.push_back(pix_row(24'h90FF20));
        dir_rows.push_back(pix_row(24'h913F20));
        // Only pure white is transparent here.
        dir_rows.push_back(cfg_row(CFG_KEY_COLOR, 24'hFFFFFF));
        dir_rows.push_back(cfg_row(CFG_KEY_TOLERANCE, 24'hFFFFFF));
        dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 24'h000003));
        dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 24'h000002));
        dir_rows.push_back(pix_row(24'hFFFFFF));
        dir_rows.push_back(pix_row(24'hFFFFFE));
        dir_rows.push_back(pix_row(24'h00FFFF));
        dir_rows.push_back(pix_row(24'h000000));
        dir_rows.push_back(pix_row(24'hFFFFFF));
        dir_rows.push_back(pix_row(24'hFFFF00));
        // A frame with no opaque pixel at all.
        dir_rows.push_back(cfg_row(CFG_KEY_COLOR, 24'h000000));
        dir_rows.push_back(cfg_row(CFG_KEY_TOLERANCE, 24'h000000));
        dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 24'h000002));
        dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 24'h000002));
        dir_rows.push_back(pix_row(24'h000000));
        dir_rows.push_back(pix_row(24'h000000));
        dir_rows.push_back(pix_row(24'h000000));
        dir_rows.push_back(pix_row(24'h000000, 1, rect(KIND_BOX, 0, 0, 0, 0, 1'b1, 1'b1)));
        // Shrink the width past the current column, then the height past the
        // current row, while a frame is in progress.
        dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 24'h000003));
        dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 24'h000003));
        dir_rows.push_back(pix_row(24'hFFFFFF));
        dir_rows.push_back(pix_row(24'hFFFFFF));
        dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 24'h000001));
        dir_rows.push_back(pix_row(24'h000000));
        dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 24'h000001));
        dir_rows.push_back(pix_row(24'hFFFFFF));

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
                send_pixel(dir_rows[i].value, dir_rows[i].n_typed, dir_rows[i].want0,
                           dir_rows[i].want1);
        end

        stop_at = pixels_in + RANDOM_ITEMS;
        while (pixels_in < stop_at) begin
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 3))
                    0: wdata = 24'h000000;
                    1: wdata = 24'hFFFFFF;
                    default: wdata = KEY_W'($urandom());
                endcase
                write_reg(CFG_KEY_COLOR, wdata);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 3))
                    0: wdata = 24'h000000;
                    1: wdata = 24'hFFFFFF;
                    2: wdata = KEY_W'($urandom());
                    default: wdata = KEY_W'($urandom()) & 24'h0F0F0F;
                endcase
                write_reg(CFG_KEY_TOLERANCE, wdata);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0: wv = 0;
                    1: wv = $urandom_range(13, 40);
                    default: wv = $urandom_range(1, 12);
                endcase
                wdata = KEY_W'(wv);
                if ($urandom_range(0, 3) == 0) wdata[KEY_W-1:COORD_W] = 11'($urandom());
                write_reg(CFG_FRAME_WIDTH, wdata);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0: wv = 0;
                    1: wv = $urandom_range(7, 12);
                    default: wv = $urandom_range(1, 6);
                endcase
                wdata = KEY_W'(wv);
                if ($urandom_range(0, 3) == 0) wdata[KEY_W-1:COORD_W] = 11'($urandom());
                write_reg(CFG_FRAME_HEIGHT, wdata);
            end
            // Whole frames, sometimes with a partial one left over so that the
            // next size change lands in the middle of a frame.
            fr = $urandom_range(1, 3);
            n  = fr * dim(width_q) * dim(height_q);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, dim(width_q) * dim(height_q));
            if (n > stop_at - pixels_in) n = stop_at - pixels_in;
            stream_pixels(n);
        end

        // Line up on a frame start, then a wide row and a tall column with the
        // size clamped to the maximum, each cut short by a size change.
        write_reg(CFG_FRAME_WIDTH, 24'h000001);
        write_reg(CFG_FRAME_HEIGHT, 24'h000001);
        send_pixel(KEY_W'($urandom()));
        write_reg(CFG_KEY_COLOR, 24'h808080);
        write_reg(CFG_KEY_TOLERANCE, 24'h202020);
        write_reg(CFG_FRAME_WIDTH, 24'h001FFF);
        stream_pixels(WIDE_PIXELS);
        send_pixel(24'h909090);
        send_pixel(24'h000000);
        write_reg(CFG_FRAME_WIDTH, 24'h7F0001);
        write_reg(CFG_FRAME_HEIGHT, 24'h7F1FFF);
        stream_pixels(TALL_PIXELS);
        write_reg(CFG_FRAME_HEIGHT, 24'h000001);
        send_pixel(24'h000000);

        @(negedge i_clk);
        i_valid = 1'b0;
        drain = 0;
        while (expected_rects.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (expected_rects.size() != 0) begin
            $error("%0d expected result words never arrived", expected_rects.size());
            errors++;
        end

        $display("Streamed %0d pixels over %0d frames with %0d register writes; %0d words checked.",
                 pixels_in, frames_seen, reg_writes, words_checked);
        $display("Frames ranged from 1x1 up to sizes clamped at the maximum, under gaps and stalls.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
src/ckre_pkg.sv
src/ckre_key_match.sv
src/ckre_run_track.sv
src/ckre_out_fifo.sv
src/color_key_run_extractor_top.sv
verif/testbench.sv
